@@ hw/rtl/swfr_pkg.sv @@
// Shared constants, widths and codes for the sync-word frame receiver.
`timescale 1ns / 1ps

package swfr_pkg;

  localparam int WORD_RING_DEPTH = 1024;
  localparam int LIST_DEPTH      = 32;

  localparam int WORD_IDX_W = $clog2(WORD_RING_DEPTH);
  localparam int LIST_IDX_W = $clog2(LIST_DEPTH);
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int CNT_W      = 11;
  localparam int MAXW_W     = 10;
  localparam int EV_W       = 3;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [BYTE_W-1:0] SYNC_A    = 8'h13;
  localparam logic [BYTE_W-1:0] SYNC_B    = 8'hAC;
  localparam logic [WORD_W-1:0] SUM_SEED  = 16'hAC13;
  localparam logic [CNT_W-1:0]  LEN_WORD  = 11'd4;
  localparam logic [CNT_W-1:0]  HDR_WORDS = 11'd5;
  localparam logic [CNT_W-1:0]  CNT_ALL1  = '1;
  localparam logic [MAXW_W-1:0] MAXW_RST  = 10'd256;

  // register index carried in the word-address bits of paddr
  localparam logic [CFG_ADDR_W-3:0] REG_MAX_PAYLOAD = '0;

  typedef enum logic [1:0] {
    PH_SYNC_A,
    PH_SYNC_B,
    PH_LOW,
    PH_HIGH
  } phase_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE      = 3'd0,
    EV_ACCEPT    = 3'd1,
    EV_CSUM_BAD  = 3'd2,
    EV_LEN_BAD   = 3'd3,
    EV_RING_FULL = 3'd4,
    EV_LIST_FULL = 3'd5
  } event_t;

endpackage

@@ hw/rtl/swfr_if.sv @@
// Valid/ready channel interfaces for received bytes and result beats.
`timescale 1ns / 1ps

interface swfr_in_if import swfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BYTE_W-1:0]     rx_byte;
  logic [WORD_IDX_W-1:0] word_fetch_index;
  logic [LIST_IDX_W-1:0] list_fetch_index;

  modport source (output valid, rx_byte, word_fetch_index, list_fetch_index, input ready);
  modport sink   (input valid, rx_byte, word_fetch_index, list_fetch_index, output ready);
endinterface

interface swfr_out_if import swfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  word_write_valid;
  logic [WORD_IDX_W-1:0] word_write_index;
  logic [WORD_W-1:0]     word_write_data;
  logic                  list_write_valid;
  logic [LIST_IDX_W-1:0] list_write_index;
  logic [WORD_IDX_W-1:0] list_write_data;
  logic [WORD_IDX_W-1:0] word_put_index;
  logic [LIST_IDX_W-1:0] list_put_index;
  logic [EV_W-1:0]       event_code;

  modport source (output valid, word_write_valid, word_write_index, word_write_data,
                  list_write_valid, list_write_index, list_write_data,
                  word_put_index, list_put_index, event_code, input ready);
  modport sink   (input valid, word_write_valid, word_write_index, word_write_data,
                  list_write_valid, list_write_index, list_write_data,
                  word_put_index, list_put_index, event_code, output ready);
endinterface

@@ hw/rtl/sync_word_frame_receiver_core.sv @@
// Sync-word frame receiver: byte-stream deframer feeding a word ring and message list.
`timescale 1ns / 1ps

// Takes one received byte per beat and gives exactly one result beat per byte.
// The parser hunts for 0x13 then 0xAC (extra 0x13 bytes before the 0xAC are
// fine), then pairs bytes into little-endian words, summing them onto a seed
// of 0xAC13. Word 4 holds the byte length; half of it above max_payload_words
// drops the frame. Words are reported as writes into the word ring; word
// length/2+5 is the checksum and is not written. A zero sum commits the frame:
// its start index is reported as a message-list write and word_put_index moves
// to the end of the frame. A full word ring (next write slot equals the
// consumer's fetch index) or full message list drops the frame, and every drop
// or commit returns to sync hunting. Throughput is one byte per clock: all
// per-byte work sits between the accepted beat and a single output register,
// and in_ch.ready stays high while that register is empty or being drained.
// max_payload_words (reset 256) lives at APB byte address 0; write it only
// while the block is idle.
module sync_word_frame_receiver_core import swfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  swfr_in_if.sink               in_ch,
  swfr_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // parser state
  phase_t                phase_r, phase_nxt;
  logic [BYTE_W-1:0]     low_byte_r, low_byte_nxt;
  logic [WORD_W-1:0]     sum_r, sum_nxt;
  logic [WORD_IDX_W-1:0] wcur_r, wcur_nxt;
  logic [WORD_IDX_W-1:0] wput_r, wput_nxt;
  logic [LIST_IDX_W-1:0] lput_r, lput_nxt;
  logic [CNT_W-1:0]      wcnt_r, wcnt_nxt;
  logic [CNT_W-1:0]      fwords_r, fwords_nxt;
  logic [MAXW_W-1:0]     max_words_r;

  // output beat register
  logic                  ovalid_r;
  logic                  o_wv_r, o_wv_nxt;
  logic [WORD_IDX_W-1:0] o_wi_r, o_wi_nxt;
  logic [WORD_W-1:0]     o_wd_r, o_wd_nxt;
  logic                  o_lv_r, o_lv_nxt;
  logic [LIST_IDX_W-1:0] o_li_r, o_li_nxt;
  logic [WORD_IDX_W-1:0] o_ld_r, o_ld_nxt;
  event_t                o_ev_r, o_ev_nxt;

  logic                  in_fire;
  logic [BYTE_W-1:0]     rx;
  logic [WORD_IDX_W-1:0] wcur_inc;
  logic [LIST_IDX_W-1:0] lput_inc;
  logic [WORD_W-1:0]     word;
  logic [WORD_W-2:0]     len;
  logic                  ring_full, len_bad, is_len_word, is_csum_word, list_full;

  // ---------------- handshake ----------------
  // output register parts the two sides: take a byte whenever the slot frees up
  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rx          = in_ch.rx_byte;

  // ---------------- APB register ----------------
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1:2] == REG_MAX_PAYLOAD) begin
      prdata = CFG_DATA_W'(max_words_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_words_r <= MAXW_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CFG_ADDR_W-1:2] == REG_MAX_PAYLOAD) begin
      max_words_r <= pwdata[MAXW_W-1:0];
    end
  end

  // ---------------- high-byte conditions ----------------
  assign wcur_inc     = wcur_r + 1'b1;              // wraps at ring depth
  assign lput_inc     = lput_r + 1'b1;
  assign word         = {rx, low_byte_r};
  assign len          = word[WORD_W-1:1];
  assign ring_full    = wcur_inc == in_ch.word_fetch_index;
  assign list_full    = lput_inc == in_ch.list_fetch_index;
  assign len_bad      = len > (WORD_W-1)'(max_words_r);
  assign is_len_word  = wcnt_r == LEN_WORD;
  assign is_csum_word = (wcnt_r > LEN_WORD) && (wcnt_r == fwords_r);

  // ---------------- next phase ----------------
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_SYNC_A: begin
        if (rx == SYNC_A) phase_nxt = PH_SYNC_B;
      end
      PH_SYNC_B: begin
        if (rx == SYNC_B) begin
          phase_nxt = PH_LOW;
        end else if (rx != SYNC_A) begin
          phase_nxt = PH_SYNC_A;
        end
      end
      PH_LOW: phase_nxt = PH_HIGH;
      PH_HIGH: begin
        // any drop or commit goes back to hunting
        if (ring_full || (is_len_word && len_bad) || is_csum_word) begin
          phase_nxt = PH_SYNC_A;
        end else begin
          phase_nxt = PH_LOW;
        end
      end
      default: phase_nxt = PH_SYNC_A;
    endcase
  end

  // ---------------- datapath and result ----------------
  always_comb begin
    low_byte_nxt = low_byte_r;
    sum_nxt      = sum_r;
    wcur_nxt     = wcur_r;
    wput_nxt     = wput_r;
    lput_nxt     = lput_r;
    wcnt_nxt     = wcnt_r;
    fwords_nxt   = fwords_r;
    o_wv_nxt     = 1'b0;
    o_wi_nxt     = '0;
    o_wd_nxt     = '0;
    o_lv_nxt     = 1'b0;
    o_li_nxt     = '0;
    o_ld_nxt     = '0;
    o_ev_nxt     = EV_NONE;
    case (phase_r)
      PH_SYNC_A: ;
      PH_SYNC_B: begin
        if (rx == SYNC_B) begin
          sum_nxt    = SUM_SEED;
          wcur_nxt   = wput_r;
          wcnt_nxt   = '0;
          fwords_nxt = CNT_ALL1;
        end
      end
      PH_LOW: begin
        low_byte_nxt = rx;
        sum_nxt      = sum_r + WORD_W'(rx);
      end
      PH_HIGH: begin
        if (ring_full) begin
          o_ev_nxt = EV_RING_FULL;
        end else begin
          sum_nxt = sum_r + {rx, {BYTE_W{1'b0}}};
          if (is_len_word && len_bad) begin
            o_ev_nxt = EV_LEN_BAD;
          end else if (is_csum_word) begin
            if (list_full) begin
              wcur_nxt = wput_r;
              o_ev_nxt = EV_LIST_FULL;
            end else if (sum_nxt == '0) begin
              o_lv_nxt = 1'b1;
              o_li_nxt = lput_r;
              o_ld_nxt = wput_r;
              wput_nxt = wcur_r;
              lput_nxt = lput_inc;
              o_ev_nxt = EV_ACCEPT;
            end else begin
              o_ev_nxt = EV_CSUM_BAD;
            end
          end else begin
            if (is_len_word) begin
              fwords_nxt = CNT_W'(len) + HDR_WORDS;
            end
            o_wv_nxt = 1'b1;
            o_wi_nxt = wcur_r;
            o_wd_nxt = word;
            wcur_nxt = wcur_inc;
            wcnt_nxt = wcnt_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SYNC_A;
      low_byte_r <= '0;
      sum_r      <= '0;
      wcur_r     <= '0;
      wput_r     <= '0;
      lput_r     <= '0;
      wcnt_r     <= '0;
      fwords_r   <= CNT_ALL1;
      ovalid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r    <= phase_nxt;
        low_byte_r <= low_byte_nxt;
        sum_r      <= sum_nxt;
        wcur_r     <= wcur_nxt;
        wput_r     <= wput_nxt;
        lput_r     <= lput_nxt;
        wcnt_r     <= wcnt_nxt;
        fwords_r   <= fwords_nxt;
        ovalid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r   <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted byte
  always_ff @(posedge clk) begin
    if (in_fire) begin
      o_wv_r <= o_wv_nxt;
      o_wi_r <= o_wi_nxt;
      o_wd_r <= o_wd_nxt;
      o_lv_r <= o_lv_nxt;
      o_li_r <= o_li_nxt;
      o_ld_r <= o_ld_nxt;
      o_ev_r <= o_ev_nxt;
    end
  end

  // put indexes are shown as they stand after the byte that made the beat;
  // they only move on a fire, which also reloads the beat
  assign out_ch.valid            = ovalid_r;
  assign out_ch.word_write_valid = o_wv_r;
  assign out_ch.word_write_index = o_wi_r;
  assign out_ch.word_write_data  = o_wd_r;
  assign out_ch.list_write_valid = o_lv_r;
  assign out_ch.list_write_index = o_li_r;
  assign out_ch.list_write_data  = o_ld_r;
  assign out_ch.word_put_index   = wput_r;
  assign out_ch.list_put_index   = lput_r;
  assign out_ch.event_code       = o_ev_r;

endmodule

@@ tb/tb_sync_word_frame_receiver_core.sv @@
// Self-checking testbench for the sync-word frame receiver core.
`timescale 1ns / 1ps

// Bytes go in on in_ch with random gaps, result beats come back on out_ch
// under random back-pressure. Every accepted byte is run through a local
// deframer model, which pushes the ring/list update it should cause. Each
// result beat is checked field by field against the oldest pending update.
//
// The run has a short scripted part, then random frames in several limit
// settings:
//   - extreme byte and index values while hunting
//   - repeated 0x13 before 0xAC
//   - a ring-full drop whose high byte is 0x13, to show that the dropping
//     byte is not taken as a sync byte
//   - a length one above the limit
//   - a list-full drop on a frame with a good checksum
// Random frames are mostly well formed, with random headers and payload.
// Mixed in are noise, truncated frames, bad checksums, lengths at and past
// the limit, forced ring-full and list-full fetch indexes, and a few long
// frames that wrap the word ring.
// max_payload_words is only changed while nothing is in flight, and each
// write is read back.
module tb_sync_word_frame_receiver_core;
  import swfr_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = {REG_MAX_PAYLOAD, 2'b00};

  // one result beat, as the block reports it
  typedef struct packed {
    logic                  wr_valid;
    logic [WORD_IDX_W-1:0] wr_index;
    logic [WORD_W-1:0]     wr_data;
    logic                  msg_valid;
    logic [LIST_IDX_W-1:0] msg_index;
    logic [WORD_IDX_W-1:0] msg_start;
    logic [WORD_IDX_W-1:0] word_put;
    logic [LIST_IDX_W-1:0] list_put;
    event_t                code;
  } ring_update_t;

  // scripted byte; when pinned, the beat is known by eye: nothing written, puts at zero
  typedef struct packed {
    logic [BYTE_W-1:0]     rx;
    logic [WORD_IDX_W-1:0] wfetch;
    logic [LIST_IDX_W-1:0] lfetch;
    bit                    pinned;
    event_t                code;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  swfr_in_if  in_ch ();
  swfr_out_if out_ch ();

  sync_word_frame_receiver_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the deframer state
  phase_t                ph;
  logic [BYTE_W-1:0]     lo_latch;
  logic [WORD_W-1:0]     csum;
  logic [WORD_IDX_W-1:0] wr_cur;
  logic [WORD_IDX_W-1:0] commit_put;
  logic [LIST_IDX_W-1:0] msg_put;
  logic [CNT_W-1:0]      words_seen;
  logic [CNT_W-1:0]      frame_words;
  logic [MAXW_W-1:0]     max_words;

  ring_update_t ring_updates_q [$];

  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned sink_wait  = 0;
  int unsigned pause;
  bit          src_calm   = 1'b0;
  bit          sink_calm  = 1'b0;
  ring_update_t got_beat;
  ring_update_t t_pin;
  logic [CFG_DATA_W-1:0] rd_limit;
  logic [MAXW_W-1:0]     limit_plan [5] = '{10'd0, 10'd1023, 10'd1018, 10'd1, 10'd20};

  // Scripted bytes, starting from reset with the limit at 256.
  script_row_t script [34] = '{
    // hunting: extremes of every field, nothing happens
    '{8'h00, 10'h000, 5'h00, 1'b1, EV_NONE},
    '{8'hFF, 10'h3FF, 5'h1F, 1'b1, EV_NONE},
    // 0x13 0x13 0xAC: repeated first sync byte is tolerated
    '{8'h13, 10'h155, 5'h0A, 1'b1, EV_NONE},
    '{8'h13, 10'h2AA, 5'h15, 1'b1, EV_NONE},
    '{8'hAC, 10'h000, 5'h00, 1'b1, EV_NONE},
    // first word: next slot 1 equals fetch 1, ring full on the high byte
    '{8'hFF, 10'h000, 5'h00, 1'b1, EV_NONE},
    '{8'h13, 10'h001, 5'h00, 1'b1, EV_RING_FULL},
    // the dropping 0x13 did not arm sync, so this 0xAC is ignored
    '{8'hAC, 10'h000, 5'h00, 1'b1, EV_NONE},
    '{8'h13, 10'h000, 5'h00, 1'b1, EV_NONE},
    '{8'hAC, 10'h000, 5'h00, 1'b1, EV_NONE},
    // header words 0000 FFFF 1234 AA55
    '{8'h00, 10'h3FF, 5'h1F, 1'b0, EV_NONE},
    '{8'h00, 10'h3FF, 5'h1F, 1'b0, EV_NONE},
    '{8'hFF, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'hFF, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'h34, 10'h200, 5'h10, 1'b0, EV_NONE},
    '{8'h12, 10'h200, 5'h10, 1'b0, EV_NONE},
    '{8'h55, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'hAA, 10'h000, 5'h00, 1'b0, EV_NONE},
    // length 0x0202: 257 words, one past the limit
    '{8'h02, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'h02, 10'h000, 5'h00, 1'b1, EV_LEN_BAD},
    '{8'h13, 10'h000, 5'h00, 1'b1, EV_NONE},
    '{8'hAC, 10'h000, 5'h00, 1'b1, EV_NONE},
    // header 0000 FFFF 8001 7FFE, length 1 (no payload), checksum 53EE
    '{8'h00, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'h00, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'hFF, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'hFF, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'h01, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'h80, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'hFE, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'h7F, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'h01, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'h00, 10'h000, 5'h00, 1'b0, EV_NONE},
    '{8'hEE, 10'h000, 5'h00, 1'b0, EV_NONE},
    // good sum, but slot 0 + 1 equals list fetch 1: list full wins
    '{8'h53, 10'h000, 5'h01, 1'b1, EV_LIST_FULL}
  };

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("sync_word_frame_receiver_core test failed");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) flag_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  function automatic void clear_deframer();
    ph          = PH_SYNC_A;
    lo_latch    = '0;
    csum        = '0;
    wr_cur      = '0;
    commit_put  = '0;
    msg_put     = '0;
    words_seen  = '0;
    frame_words = CNT_ALL1;
    max_words   = MAXW_RST;
  endfunction

  // Advance the local deframer by one byte and give the beat it must produce.
  function automatic void deframe_byte(input logic [BYTE_W-1:0] b,
                                       input logic [WORD_IDX_W-1:0] wf,
                                       input logic [LIST_IDX_W-1:0] lf,
                                       output ring_update_t upd);
    logic [WORD_IDX_W-1:0] nxt;
    logic [WORD_W-1:0]     word;
    logic [LIST_IDX_W-1:0] nxt_slot;
    bit                    keep;
    upd      = '0;
    upd.code = EV_NONE;
    case (ph)
      PH_SYNC_A: begin
        if (b == SYNC_A) ph = PH_SYNC_B;
      end
      PH_SYNC_B: begin
        if (b == SYNC_B) begin
          ph          = PH_LOW;
          csum        = SUM_SEED;
          wr_cur      = commit_put;
          words_seen  = '0;
          frame_words = CNT_ALL1;
        end else if (b != SYNC_A) begin
          ph = PH_SYNC_A;
        end
      end
      PH_LOW: begin
        lo_latch = b;
        csum     = csum + b;
        ph       = PH_HIGH;
      end
      default: begin
        nxt  = wr_cur + 1'b1;
        word = {b, lo_latch};
        keep = 1'b1;
        // ring full is tested ahead of everything, checksum word included
        if (nxt == wf) begin
          ph       = PH_SYNC_A;
          upd.code = EV_RING_FULL;
          keep     = 1'b0;
        end else begin
          csum = csum + {b, 8'h00};
          if (words_seen == LEN_WORD) begin
            if (word[15:1] > max_words) begin
              ph       = PH_SYNC_A;
              upd.code = EV_LEN_BAD;
              keep     = 1'b0;
            end else begin
              frame_words = CNT_W'(word[15:1]) + HDR_WORDS;
            end
          end else if (words_seen > LEN_WORD && words_seen == frame_words) begin
            // checksum word: summed, never written
            keep     = 1'b0;
            ph       = PH_SYNC_A;
            nxt_slot = msg_put + 1'b1;
            if (nxt_slot == lf) begin
              wr_cur   = commit_put;
              upd.code = EV_LIST_FULL;
            end else if (csum == '0) begin
              upd.msg_valid = 1'b1;
              upd.msg_index = msg_put;
              upd.msg_start = commit_put;
              commit_put    = wr_cur;
              msg_put       = nxt_slot;
              upd.code      = EV_ACCEPT;
            end else begin
              upd.code = EV_CSUM_BAD;
            end
          end
        end
        if (keep) begin
          upd.wr_valid = 1'b1;
          upd.wr_index = wr_cur;
          upd.wr_data  = word;
          wr_cur       = nxt;
          words_seen   = words_seen + 1'b1;
          ph           = PH_LOW;
        end
      end
    endcase
    upd.word_put = commit_put;
    upd.list_put = msg_put;
  endfunction

  // One input beat: optional gap, then hold valid until the block takes it.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [WORD_IDX_W-1:0] wf,
                           input logic [LIST_IDX_W-1:0] lf);
    int unsigned  gap;
    ring_update_t upd;
    gap = src_calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.rx_byte          <= b;
    in_ch.word_fetch_index <= wf;
    in_ch.list_fetch_index <= lf;
    do @(posedge clk); while (!in_ch.ready);
    deframe_byte(b, wf, lf, upd);
    ring_updates_q.push_back(upd);
    bytes_sent++;
  endtask

  // Noise, sync, header, length, payload and checksum, with faults mixed in.
  task automatic send_frame();
    logic [WORD_W-1:0]     words [$];
    logic [WORD_W-1:0]     sum;
    logic [WORD_W-1:0]     len_word;
    logic [WORD_IDX_W-1:0] wf;
    logic [LIST_IDX_W-1:0] lf;
    int unsigned           sel, count, noise, reps, cut, i;
    int                    full_at;
    bit                    legal;
    src_calm = ($urandom_range(0, 3) == 0);
    noise = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
    repeat (noise) send_byte(8'($urandom), 10'($urandom), 5'($urandom));
    reps = $urandom_range(0, 2);
    repeat (reps) send_byte(SYNC_A, 10'($urandom), 5'($urandom));
    send_byte(SYNC_A, 10'($urandom), 5'($urandom));
    send_byte(SYNC_B, 10'($urandom), 5'($urandom));

    repeat (4) words.push_back(16'($urandom));
    count = 0;
    sel   = $urandom_range(0, 99);
    if (sel < 10) begin
      // one word past the limit
      len_word = 16'(((max_words + 1) << 1) | $urandom_range(0, 1));
    end else if (sel < 14) begin
      len_word = 16'($urandom_range(2 * (max_words + 1), 65535));
    end else begin
      if (sel < 22 && max_words <= 48) count = max_words;
      else if (sel < 25 && max_words >= 600) count = $urandom_range(100, 600);
      else count = $urandom_range(0, (max_words < 12) ? max_words : 12);
      len_word = 16'((count << 1) | $urandom_range(0, 1));
    end
    legal = (len_word[15:1] <= max_words);
    words.push_back(len_word);
    if (legal) begin
      repeat (count) words.push_back(16'($urandom));
      sum = SUM_SEED;
      foreach (words[k]) sum = sum + words[k];
      sum = -sum;
      if ($urandom_range(0, 9) == 0) sum = sum ^ 16'($urandom_range(1, 65535));
      words.push_back(sum);
    end

    cut     = ($urandom_range(0, 19) == 0) ? $urandom_range(0, words.size() - 1)
                                           : words.size();
    full_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, words.size() - 1) : -1;
    for (i = 0; i < cut; i++) begin
      send_byte(words[i][7:0], 10'($urandom), 5'($urandom));
      // force the fetch index onto the next slot to make the ring look full
      wf = (i == full_at) ? wr_cur + 1'b1 : 10'($urandom);
      lf = (legal && i == words.size() - 1 && $urandom_range(0, 7) == 0) ? msg_put + 1'b1
                                                                          : 5'($urandom);
      send_byte(words[i][15:8], wf, lf);
    end
  endtask

  // Stop sending and wait until every expected beat has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (ring_updates_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_limit(output logic [CFG_DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the limit (upper bus bits are junk, the block keeps 10) and read it back.
  task automatic program_limit(input logic [MAXW_W-1:0] v);
    logic [CFG_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {22'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_words = v;
    @(posedge clk);
    read_limit(rd);
    check_field("max_payload_words readback", rd, v);
  endtask

  task automatic check_update(input ring_update_t got);
    ring_update_t want;
    if (ring_updates_q.size() == 0) begin
      flag_mismatch("result beat with nothing expected");
    end else begin
      want = ring_updates_q.pop_front();
      check_field("word_write_valid", got.wr_valid, want.wr_valid);
      check_field("word_write_index", got.wr_index, want.wr_index);
      check_field("word_write_data", got.wr_data, want.wr_data);
      check_field("list_write_valid", got.msg_valid, want.msg_valid);
      check_field("list_write_index", got.msg_index, want.msg_index);
      check_field("list_write_data", got.msg_start, want.msg_start);
      check_field("word_put_index", got.word_put, want.word_put);
      check_field("list_put_index", got.list_put, want.list_put);
      check_field("event_code", got.code, want.code);
    end
  endtask

  // Result side: check each accepted beat, then maybe drop ready for a random pause.
  // Every 64 beats it may switch to a stall-free stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait    <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      got_beat.wr_valid  = out_ch.word_write_valid;
      got_beat.wr_index  = out_ch.word_write_index;
      got_beat.wr_data   = out_ch.word_write_data;
      got_beat.msg_valid = out_ch.list_write_valid;
      got_beat.msg_index = out_ch.list_write_index;
      got_beat.msg_start = out_ch.list_write_data;
      got_beat.word_put  = out_ch.word_put_index;
      got_beat.list_put  = out_ch.list_put_index;
      got_beat.code      = event_t'(out_ch.event_code);
      check_update(got_beat);
      beats_seen++;
      if (beats_seen % 64 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      pause = sink_calm ? 0 : $urandom_range(0, 5);
      if (pause != 0) begin
        out_ch.ready <= 1'b0;
        sink_wait    <= pause - 1;
      end
    end else if (!out_ch.ready) begin
      if (sink_wait == 0) out_ch.ready <= 1'b1;
      else sink_wait <= sink_wait - 1;
    end
  end

  initial begin
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    in_ch.valid            = 1'b0;
    in_ch.rx_byte          = '0;
    in_ch.word_fetch_index = '0;
    in_ch.list_fetch_index = '0;
    clear_deframer();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_limit(rd_limit);
    check_field("max_payload_words after reset", rd_limit, MAXW_RST);

    // scripted part
    foreach (script[r]) begin
      send_byte(script[r].rx, script[r].wfetch, script[r].lfetch);
      if (script[r].pinned) begin
        t_pin      = '0;
        t_pin.code = script[r].code;
        ring_updates_q[ring_updates_q.size() - 1] = t_pin;
      end
    end

    // random frames: reset limit first, then each planned limit. Each change
    // waits for the pipe to empty, which also gives a full stop on the input.
    limit_plan[4] = 10'($urandom_range(2, 40));
    for (int p = 0; p < 6; p++) begin
      int unsigned goal;
      if (p != 0) begin
        drain_results();
        program_limit(limit_plan[p - 1]);
      end
      goal = bytes_sent + 250;
      while (bytes_sent < goal) send_frame();
    end

    drain_results();
    if (mismatches == 0) begin
      $display("sync_word_frame_receiver_core test passed");
    end else begin
      $display("sync_word_frame_receiver_core test failed");
    end
    $finish;
  end

endmodule
